// ----- hdl/rms_vector_normalizer_top_defines.svh -----
// Assertion macros shared by the checker of the RMS vector normalizer.
// No dependencies.
`ifndef RMS_VECTOR_NORMALIZER_TOP_DEFINES_SVH
`define RMS_VECTOR_NORMALIZER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define RMSN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RMSN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/rmsn_pkg.sv -----
// Package of the RMS vector normalizer: constants and the controller state type.
// No dependencies.
package rmsn_pkg;
  localparam int unsigned MaxLength   = 64;
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned FracBits    = 12;
  localparam logic [31:0] EpsReset    = 32'd17;
  localparam int unsigned SumW        = 64;
  localparam int unsigned RootW       = 32;

  typedef enum logic [2:0] {
    StCollect,
    StDiv,
    StSqrt,
    StRead,
    StQuot,
    StOut
  } state_e;
endpackage

// ----- hdl/rms_vector_normalizer_top.sv -----
// RMS normalizer: samples are stored as they arrive, one input item per cycle while the
// block collects; intake stalls otherwise. The last one starts a bit-serial divide by the
// count and a bit-serial square root with a load step first. Each element then takes a
// buffer read and a restoring divide; the next element is read only after the output
// accepts the current result.
// Reset is asynchronous and clears count, sum, state and epsilon (to 17), not the buffer.
module rms_vector_normalizer_top #(
  parameter int unsigned MAX_LENGTH   = rmsn_pkg::MaxLength,
  parameter int unsigned SAMPLE_WIDTH = rmsn_pkg::SampleWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [31:0]             cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                    is_last_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SAMPLE_WIDTH-1:0] normalized_o,
  output logic                    saturated_o,
  output logic                    end_of_vector_o
);
  localparam int unsigned AW   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned CW   = $clog2(MAX_LENGTH + 1);
  localparam int unsigned SW   = rmsn_pkg::SumW;
  localparam int unsigned RW   = rmsn_pkg::RootW;
  localparam int unsigned NW   = SAMPLE_WIDTH + rmsn_pkg::FracBits;
  localparam int unsigned SBW  = $clog2(SW);
  localparam int unsigned NBW  = $clog2(NW + 1);

  logic [SAMPLE_WIDTH-1:0] mem_q [MAX_LENGTH];
  logic [SAMPLE_WIDTH-1:0] rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  rmsn_pkg::state_e state_q, state_d;
  logic [31:0] eps_q;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [SW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [SBW-1:0] bit_q, bit_d;
  logic [RW-1:0] root_q, root_d;
  logic [NW-1:0] num_q, num_d, nq_q, nq_d;
  logic [RW:0] nrem_q, nrem_d;
  logic [NBW-1:0] nbit_q, nbit_d;
  logic neg_q, neg_d;
  logic [SAMPLE_WIDTH-1:0] res_q, res_d;
  logic sat_q, sat_d, eov_q, eov_d;

  logic [SAMPLE_WIDTH-1:0] mag_in, mag_rd;
  logic [2*SAMPLE_WIDTH-1:0] sq;
  logic [SW:0] sum_ext, ms_ext, rem_sh, sq_try;
  logic [RW:0] nrem_sh;
  logic [SW-1:0] sq_rem_sh;
  logic [RW+1:0] sq_cand;
  logic accept_in, last_in;

  assign accept_in = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != rmsn_pkg::StCollect);
  assign out_valid_o = (state_q == rmsn_pkg::StOut);
  assign normalized_o = res_q;
  assign saturated_o = sat_q;
  assign end_of_vector_o = eov_q;
  assign mem_we = accept_in;
  assign rd_addr = idx_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cnt_q[AW-1:0]] <= sample_i;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Two's-complement magnitude; the most negative code maps to itself.
  assign mag_in = sample_i[SAMPLE_WIDTH-1] ? (~sample_i + 1'b1) : sample_i;
  assign mag_rd = rd_data_q[SAMPLE_WIDTH-1] ? (~rd_data_q + 1'b1) : rd_data_q;
  assign sq = mag_in * mag_in;
  assign sum_ext = {1'b0, sum_q} + {{(SW+1-2*SAMPLE_WIDTH){1'b0}}, sq};
  assign last_in = is_last_i || (cnt_q + 1'b1 >= CW'(MAX_LENGTH));

  assign rem_sh = {rem_q, quo_q[SW-1]};
  assign ms_ext = {1'b0, quo_q} + {{(SW-31){1'b0}}, eps_q};
  // Square root: one result bit per cycle from the top pair of radicand bits.
  assign sq_rem_sh = {rem_q[SW-3:0], quo_q[SW-1:SW-2]};
  assign sq_cand = {root_q, 2'b01};
  assign sq_try = {1'b0, sq_rem_sh} - {{(SW-RW-1){1'b0}}, sq_cand};
  assign nrem_sh = {nrem_q[RW-1:0], num_q[NW-1]};

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; sum_d = sum_q;
    rem_d = rem_q; quo_d = quo_q; bit_d = bit_q; root_d = root_q;
    num_d = num_q; nq_d = nq_q; nrem_d = nrem_q; nbit_d = nbit_q;
    neg_d = neg_q; res_d = res_q; sat_d = sat_q; eov_d = eov_q;
    unique case (state_q)
      rmsn_pkg::StCollect: begin
        if (accept_in) begin
          cnt_d = cnt_q + 1'b1;
          sum_d = sum_ext[SW] ? '1 : sum_ext[SW-1:0];
          if (last_in) begin
            state_d = rmsn_pkg::StDiv;
            quo_d = sum_ext[SW] ? '1 : sum_ext[SW-1:0];
            rem_d = '0;
            bit_d = '0;
          end
        end
      end
      rmsn_pkg::StDiv: begin
        if (rem_sh >= {{(SW+1-CW){1'b0}}, cnt_q}) begin
          rem_d = rem_sh[SW-1:0] - {{(SW-CW){1'b0}}, cnt_q};
          quo_d = {quo_q[SW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[SW-1:0];
          quo_d = {quo_q[SW-2:0], 1'b0};
        end
        bit_d = bit_q + 1'b1;
        if (bit_q == SBW'(SW-1)) begin
          state_d = rmsn_pkg::StSqrt;
          bit_d = '0;
          root_d = '0;
          nbit_d = '0;
        end
      end
      rmsn_pkg::StSqrt: begin
        if (nbit_q == '0) begin
          // First cycle: load the mean square plus epsilon, saturated.
          quo_d = ms_ext[SW] ? '1 : ms_ext[SW-1:0];
          nbit_d = NBW'(1);
          rem_d = '0;
        end else begin
          quo_d = {quo_q[SW-3:0], 2'b00};
          if (!sq_try[SW]) begin
            rem_d = sq_try[SW-1:0];
            root_d = {root_q[RW-2:0], 1'b1};
          end else begin
            rem_d = sq_rem_sh;
            root_d = {root_q[RW-2:0], 1'b0};
          end
          bit_d = bit_q + 1'b1;
          if (bit_q == SBW'(RW-1)) begin
            state_d = rmsn_pkg::StRead;
            idx_d = '0;
            nbit_d = '0;
          end
        end
      end
      rmsn_pkg::StRead: begin
        // The buffer read for address idx_q is registered in the first step; the second step uses it.
        if (nbit_q == '0) begin
          nbit_d = NBW'(1);
        end else begin
          neg_d = rd_data_q[SAMPLE_WIDTH-1];
          num_d = {mag_rd, {rmsn_pkg::FracBits{1'b0}}};
          nrem_d = '0;
          nq_d = '0;
          nbit_d = '0;
          state_d = rmsn_pkg::StQuot;
        end
      end
      rmsn_pkg::StQuot: begin
        if (nbit_q == NBW'(NW)) begin
          if (root_q == '0) begin
            res_d = '0; sat_d = 1'b0;
          end else if (neg_q) begin
            sat_d = (nq_q > NW'(1) << (SAMPLE_WIDTH-1));
            res_d = sat_d ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                          : SAMPLE_WIDTH'(~nq_q + 1'b1);
          end else begin
            sat_d = (nq_q > (NW'(1) << (SAMPLE_WIDTH-1)) - 1'b1);
            res_d = sat_d ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} : nq_q[SAMPLE_WIDTH-1:0];
          end
          eov_d = (idx_q + 1'b1 == cnt_q);
          state_d = rmsn_pkg::StOut;
        end else begin
          num_d = {num_q[NW-2:0], 1'b0};
          if (nrem_sh >= {1'b0, root_q}) begin
            nrem_d = nrem_sh - {1'b0, root_q};
            nq_d = {nq_q[NW-2:0], 1'b1};
          end else begin
            nrem_d = nrem_sh;
            nq_d = {nq_q[NW-2:0], 1'b0};
          end
          nbit_d = nbit_q + 1'b1;
        end
      end
      rmsn_pkg::StOut: begin
        if (!out_stall_i) begin
          if (eov_q) begin
            state_d = rmsn_pkg::StCollect;
            cnt_d = '0; sum_d = '0; root_d = '0; rem_d = '0; bit_d = '0;
            idx_d = '0; nbit_d = '0;
          end else begin
            idx_d = idx_q + 1'b1;
            nbit_d = '0;
            state_d = rmsn_pkg::StRead;
          end
        end
      end
      default: state_d = rmsn_pkg::StCollect;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmsn_pkg::StCollect;
      eps_q <= rmsn_pkg::EpsReset;
      cnt_q <= '0; idx_q <= '0; sum_q <= '0; rem_q <= '0; quo_q <= '0;
      bit_q <= '0; root_q <= '0; nbit_q <= '0;
    end else begin
      if (cfg_we_i) eps_q <= cfg_wdata_i;
      state_q <= state_d;
      cnt_q <= cnt_d; idx_q <= idx_d; sum_q <= sum_d; rem_q <= rem_d;
      quo_q <= quo_d; bit_q <= bit_d; root_q <= root_d; nbit_q <= nbit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; nq_q <= nq_d; nrem_q <= nrem_d; neg_q <= neg_d;
    res_q <= res_d; sat_q <= sat_d; eov_q <= eov_d;
  end
endmodule

// ----- hdl/rmsn_checker.sv -----
// Port-level checker for the RMS vector normalizer, bound to the top level.
// Depends on rms_vector_normalizer_top_defines.svh and rmsn_pkg.
`include "rms_vector_normalizer_top_defines.svh"
module rmsn_checker #(
  parameter int unsigned SAMPLE_WIDTH = rmsn_pkg::SampleWidth
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic [SAMPLE_WIDTH-1:0] normalized_o,
  input logic saturated_o
);
  logic out_held;
  logic out_sat;
  logic at_limit;

  assign out_held = out_valid_o && out_stall_i;
  assign out_sat = out_valid_o && saturated_o;
  assign at_limit = (normalized_o[SAMPLE_WIDTH-2:0] ==
                     {(SAMPLE_WIDTH-1){~normalized_o[SAMPLE_WIDTH-1]}});

  // Results only appear while intake is held off.
  `RMSN_ASSERT_IMP(a_out_blocks_in, clk_i, rst_ni, out_valid_o, in_stall_o)
  `RMSN_ASSERT_NXT(a_out_holds, clk_i, rst_ni, out_held, out_valid_o && $stable(normalized_o))
  // A clipped result sits at one of the two range limits.
  `RMSN_ASSERT_IMP(a_sat_limit, clk_i, rst_ni, out_sat, at_limit)
endmodule

bind rms_vector_normalizer_top rmsn_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_rmsn_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_stall_o(in_stall_o), .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i), .normalized_o(normalized_o), .saturated_o(saturated_o)
);

// ----- tb/testbench.sv -----
// Self-checking testbench of the RMS vector normalizer: random and directed vectors,
// predicted in a scoreboard class and compared item by item. Depends on rmsn_pkg
// and rms_vector_normalizer_top.
module testbench;

  typedef struct {
    logic [15:0] normalized;
    logic        saturated;
    logic        end_of_vector;
  } norm_item_t;

  class norm_scoreboard;
    logic [15:0] vec_buf[rmsn_pkg::MaxLength];
    int unsigned vec_len;
    logic [63:0] sq_total;
    logic [31:0] eps;
    norm_item_t  pending[$];
    int unsigned mismatch_cnt;
    int unsigned results_seen;
    int unsigned vectors_done;

    function void clear_state();
      vec_len = 0;
      sq_total = 0;
      eps = rmsn_pkg::EpsReset;
    endfunction

    function logic [63:0] floor_root(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_sample(logic [15:0] s, logic last);
      logic [63:0] mag;
      logic [63:0] root;
      logic [63:0] q;
      norm_item_t  it;
      mag = s[15] ? 64'(-$signed({1'b1, s})) : 64'(s);
      // The most negative sample has magnitude 2^15.
      mag = mag & 64'h1FFFF;
      vec_buf[vec_len] = s;
      vec_len++;
      sq_total = sq_total + mag * mag;
      if (!last && vec_len < rmsn_pkg::MaxLength) return;
      root = floor_root(sq_total / vec_len + 64'(eps));
      for (int k = 0; k < vec_len; k++) begin
        logic [15:0] v;
        logic [63:0] vm;
        v = vec_buf[k];
        vm = v[15] ? (64'h10000 - 64'(v)) : 64'(v);
        q = (root != 0) ? (vm << rmsn_pkg::FracBits) / root : 0;
        it.saturated = 1'b0;
        if (v[15]) begin
          if (q > 64'h8000) begin
            q = 64'h8000;
            it.saturated = 1'b1;
          end
          it.normalized = 16'(-q);
        end else begin
          if (q > 64'h7FFF) begin
            q = 64'h7FFF;
            it.saturated = 1'b1;
          end
          it.normalized = q[15:0];
        end
        it.end_of_vector = (k + 1 == vec_len);
        pending.push_back(it);
      end
      vec_len = 0;
      sq_total = 0;
      vectors_done++;
    endfunction

    function void check_result(logic [15:0] n, logic sat, logic eov);
      norm_item_t e;
      results_seen++;
      if (pending.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", n);
        return;
      end
      e = pending.pop_front();
      if (e.normalized !== n || e.saturated !== sat || e.end_of_vector !== eov) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("result mismatch: expected %h/%b/%b, got %h/%b/%b",
                   e.normalized, e.saturated, e.end_of_vector, n, sat, eov);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] sample_i = '0;
  logic        is_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] normalized_o;
  logic        saturated_o;
  logic        end_of_vector_o;

  norm_scoreboard sb;
  int unsigned    cycle_cnt = 0;
  int unsigned    samples_sent = 0;
  bit             quiet_sink = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  rms_vector_normalizer_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .sample_i(sample_i), .is_last_i(is_last_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .normalized_o(normalized_o), .saturated_o(saturated_o),
    .end_of_vector_o(end_of_vector_o)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3000000) begin
      $display("timeout");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Results are checked at the edge; the stall for the next cycle is drawn per item.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(normalized_o, saturated_o, end_of_vector_o);
      stall_left = quiet_sink ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left > 0);
  end

  task automatic send_sample(logic [15:0] s, logic last, bit gaps);
    int unsigned gap;
    gap = gaps ? ($urandom_range(0, 2) == 0 ? $urandom_range(0, 13) : 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    is_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sample(s, last);
    samples_sent++;
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    // Block may still be busy on its last result.
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_epsilon(logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.eps = v;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_vector(int unsigned len, bit gaps);
    for (int i = 0; i < len; i++)
      send_sample(rand_sample(),
                  (i == len - 1) && (len < rmsn_pkg::MaxLength || $urandom_range(0, 1)),
                  gaps);
  endtask

  initial begin
    logic [31:0] eps_set[5];
    sb = new();
    sb.clear_state();
    eps_set = '{32'd0, 32'hFFFF_FFFF, 32'd17, 32'd1, 32'h0001_0000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, single-element and one-value-dominant vectors.
    send_sample(16'h7FFF, 1'b1, 1'b0);
    send_sample(16'h8000, 1'b1, 1'b0);
    send_sample(16'h8000, 1'b0, 1'b0);
    send_sample(16'h0001, 1'b0, 1'b0);
    send_sample(16'h7FFF, 1'b1, 1'b0);
    send_sample(16'h1000, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) send_sample(16'h0000, i == 5, 1'b0);
    drain_block();
    write_epsilon(32'd0);
    // All-zero vector with zero epsilon gives a zero root.
    for (int i = 0; i < 3; i++) send_sample(16'h0000, i == 2, 1'b0);
    send_sample(16'hFFFF, 1'b1, 1'b0);
    drain_block();
    write_epsilon(32'hFFFF_FFFF);
    send_sample(16'h0001, 1'b0, 1'b0);
    send_sample(16'h8000, 1'b1, 1'b0);
    // A full-length vector with no last flag ends at the length cap.
    for (int i = 0; i < rmsn_pkg::MaxLength; i++) send_sample(16'($urandom()), 1'b0, 1'b0);
    drain_block();

    // Random phases across epsilon settings.
    for (int p = 0; p < 5; p++) begin
      write_epsilon(eps_set[p]);
      quiet_sink = (p == 3);
      while (samples_sent < 100 + p * 70)
        send_vector($urandom_range(0, 7) == 0 ? rmsn_pkg::MaxLength : $urandom_range(1, 12),
                    p != 3);
      drain_block();
    end
    quiet_sink = 1'b0;
    write_epsilon(32'($urandom()));
    while (samples_sent < 480) send_vector($urandom_range(1, 20), 1'b1);
    drain_block();

    $display("covered %0d samples in %0d vectors, %0d results", samples_sent,
             sb.vectors_done, sb.results_seen);
    $display("directed extremes, then random phases over six epsilon settings");
    if (sb.mismatch_cnt == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", sb.mismatch_cnt);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rmsn_pkg.sv
hdl/rms_vector_normalizer_top.sv
hdl/rmsn_checker.sv
tb/testbench.sv
